@@ hdl/pwm_frequency_duty_meter_assert.svh @@
// ----------------------------------------------------------------------------
// PWM meter assertion macros
// Shorthand for clocked, reset-qualified concurrent checks on clk / rst_n.
// ----------------------------------------------------------------------------
`ifndef PWM_FREQUENCY_DUTY_METER_ASSERT_SVH
`define PWM_FREQUENCY_DUTY_METER_ASSERT_SVH

// Same-cycle implication
`define PFDM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pfdm check failed");

// Next-cycle implication
`define PFDM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pfdm check failed");

`endif

@@ hdl/pfdm_pkg.sv @@
// ----------------------------------------------------------------------------
// PWM meter package
// Shared widths, constants, register indexes and inter-module structs.
// ----------------------------------------------------------------------------
package pfdm_pkg;

  localparam int COUNT_BITS     = 16;
  localparam int CLOCK_BITS     = 32;
  localparam int DUTY_BITS      = 7;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = CLOCK_BITS;

  localparam logic [DUTY_BITS-1:0]  DUTY_FULL      = 7'd100;
  localparam logic [CLOCK_BITS-1:0] CLOCK_HZ_RESET = 32'd72_000_000;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ACTIVE_CHANNEL = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CLOCK_HZ       = 1'b1;

  // Status codes
  localparam logic STATUS_OK          = 1'b0;
  localparam logic STATUS_ZERO_PERIOD = 1'b1;

  // Completed period handed from the edge tracker to the divider
  typedef struct packed {
    logic                  ch;
    logic [COUNT_BITS-1:0] period;
    logic [COUNT_BITS-1:0] high_time;
  } job_t;

  // Finished measurement
  typedef struct packed {
    logic                  ch;
    logic [CLOCK_BITS-1:0] frequency;
    logic [DUTY_BITS-1:0]  duty_percent;
    logic                  status;
  } result_t;

endpackage

@@ hdl/pfdm_if.sv @@
// ----------------------------------------------------------------------------
// PWM meter channels
// Valid/ready interfaces for capture events and measurement results.
// ----------------------------------------------------------------------------
interface pfdm_in_if;
  logic                            valid;
  logic                            ready;
  logic                            channel;
  logic [pfdm_pkg::COUNT_BITS-1:0] stamp;

  modport source (output valid, output channel, output stamp, input ready);
  modport sink   (input valid, input channel, input stamp, output ready);
endinterface

interface pfdm_out_if;
  logic                            valid;
  logic                            ready;
  logic                            out_channel;
  logic [pfdm_pkg::CLOCK_BITS-1:0] frequency;
  logic [pfdm_pkg::DUTY_BITS-1:0]  duty_percent;
  logic                            status;

  modport source (output valid, output out_channel, output frequency,
                  output duty_percent, output status, input ready);
  modport sink   (input valid, input out_channel, input frequency,
                  input duty_percent, input status, output ready);
endinterface

@@ hdl/pfdm_tracker.sv @@
// ----------------------------------------------------------------------------
// PWM meter edge tracker
// Per-channel phase, start stamp and high time; emits one job per period.
// ----------------------------------------------------------------------------
module pfdm_tracker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            fire,
  input  logic                            channel,
  input  logic [pfdm_pkg::COUNT_BITS-1:0] stamp,
  input  logic                            active_channel,
  output logic                            job_valid,
  output pfdm_pkg::job_t                  job
);

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_HIGH  = 2'd1,
    PH_LOW   = 2'd2
  } phase_t;

  phase_t                          phase_r   [2];
  phase_t                          phase_nxt [2];
  logic [pfdm_pkg::COUNT_BITS-1:0] start_r   [2];
  logic [pfdm_pkg::COUNT_BITS-1:0] high_r    [2];
  logic                            job_valid_r, job_valid_nxt;
  pfdm_pkg::job_t                  job_r;
  logic                            hit;
  logic [pfdm_pkg::COUNT_BITS-1:0] elapsed;

  assign hit     = fire && (channel == active_channel);
  assign elapsed = stamp - start_r[channel];

  // Advance the phase of the selected channel
  always_comb begin
    phase_nxt[0]  = phase_r[0];
    phase_nxt[1]  = phase_r[1];
    job_valid_nxt = 1'b0;
    if (hit) begin
      case (phase_r[channel])
        PH_HIGH: phase_nxt[channel] = PH_LOW;
        PH_LOW: begin
          phase_nxt[channel] = PH_START;
          job_valid_nxt      = 1'b1;
        end
        default: phase_nxt[channel] = PH_HIGH;
      endcase
    end
  end

  // Hold phase and job strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r[0]  <= PH_START;
      phase_r[1]  <= PH_START;
      job_valid_r <= 1'b0;
    end else begin
      phase_r[0]  <= phase_nxt[0];
      phase_r[1]  <= phase_nxt[1];
      job_valid_r <= job_valid_nxt;
    end
  end

  // Capture stamps and the finished period
  always_ff @(posedge clk) begin
    if (hit) begin
      case (phase_r[channel])
        PH_HIGH: high_r[channel] <= elapsed;
        PH_LOW: begin
          job_r.ch        <= channel;
          job_r.period    <= elapsed;
          job_r.high_time <= high_r[channel];
        end
        default: start_r[channel] <= stamp;
      endcase
    end
  end

  assign job_valid = job_valid_r;
  assign job       = job_r;

endmodule

@@ hdl/pfdm_divider.sv @@
// ----------------------------------------------------------------------------
// PWM meter serial divider
// Restoring division, one quotient bit per cycle, for frequency and duty at once.
// ----------------------------------------------------------------------------
module pfdm_divider (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  pfdm_pkg::job_t                  job,
  input  logic [pfdm_pkg::CLOCK_BITS-1:0] clock_hz,
  output logic                            idle,
  output logic                            res_valid,
  input  logic                            res_ready,
  output pfdm_pkg::result_t               result
);

  localparam int ITER_BITS = $clog2(pfdm_pkg::CLOCK_BITS);
  localparam int PROD_BITS = pfdm_pkg::COUNT_BITS + pfdm_pkg::DUTY_BITS;
  localparam int CB        = pfdm_pkg::COUNT_BITS;
  localparam int KB        = pfdm_pkg::CLOCK_BITS;
  localparam int DB        = pfdm_pkg::DUTY_BITS;
  localparam logic [ITER_BITS-1:0] LAST_ITER = ITER_BITS'(KB - 1);

  typedef enum logic [1:0] {
    D_IDLE = 2'd0,
    D_RUN  = 2'd1,
    D_DONE = 2'd2
  } dstate_t;

  dstate_t                state_r;
  logic [ITER_BITS-1:0]   cnt_r;
  logic [CB-1:0]          per_r;
  logic [KB-1:0]          fq_r, fq_nxt;
  logic [CB-1:0]          frem_r, frem_nxt;
  logic [KB-1:0]          dq_r, dq_nxt;
  logic [CB-1:0]          drem_r, drem_nxt;
  logic                   ch_r;
  logic                   status_r;
  logic [PROD_BITS-1:0]   duty_prod;
  logic [CB:0]            ftrial, dtrial;
  logic                   fge, dge;
  logic                   duty_sat;

  // Scale high time by 100 for the duty dividend
  assign duty_prod = PROD_BITS'(job.high_time) * PROD_BITS'(pfdm_pkg::DUTY_FULL);

  // One restoring step on each lane
  always_comb begin
    ftrial   = {frem_r, fq_r[KB-1]};
    fge      = ftrial >= {1'b0, per_r};
    frem_nxt = fge ? CB'(ftrial - {1'b0, per_r}) : ftrial[CB-1:0];
    fq_nxt   = {fq_r[KB-2:0], fge};
    dtrial   = {drem_r, dq_r[KB-1]};
    dge      = dtrial >= {1'b0, per_r};
    drem_nxt = dge ? CB'(dtrial - {1'b0, per_r}) : dtrial[CB-1:0];
    dq_nxt   = {dq_r[KB-2:0], dge};
  end

  // Sequence load, iterate, hold result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        D_IDLE: begin
          if (start) begin
            cnt_r   <= '0;
            state_r <= (job.period == '0) ? D_DONE : D_RUN;
          end
        end
        D_RUN: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == LAST_ITER) begin
            state_r <= D_DONE;
          end
        end
        D_DONE: begin
          if (res_ready) begin
            state_r <= D_IDLE;
          end
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state_r == D_IDLE && start) begin
      ch_r   <= job.ch;
      per_r  <= job.period;
      frem_r <= '0;
      drem_r <= '0;
      if (job.period == '0) begin
        status_r <= pfdm_pkg::STATUS_ZERO_PERIOD;
        fq_r     <= '0;
        dq_r     <= '0;
      end else begin
        status_r <= pfdm_pkg::STATUS_OK;
        fq_r     <= clock_hz;
        dq_r     <= KB'(duty_prod);
      end
    end else if (state_r == D_RUN) begin
      fq_r   <= fq_nxt;
      frem_r <= frem_nxt;
      dq_r   <= dq_nxt;
      drem_r <= drem_nxt;
    end
  end

  // Clamp duty at full scale
  assign duty_sat = (|dq_r[KB-1:DB]) || (dq_r[DB-1:0] > pfdm_pkg::DUTY_FULL);

  assign idle                = (state_r == D_IDLE);
  assign res_valid           = (state_r == D_DONE);
  assign result.ch           = ch_r;
  assign result.frequency    = fq_r;
  assign result.duty_percent = duty_sat ? pfdm_pkg::DUTY_FULL : dq_r[DB-1:0];
  assign result.status       = status_r;

endmodule

@@ hdl/pwm_frequency_duty_meter.sv @@
// ----------------------------------------------------------------------------
// PWM frequency and duty meter
// Measures period and high time of capture edges on one selected channel.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : capture beats (channel, 16-bit free-running stamp). Beats on the
//            channel not selected by active_channel are taken and dropped.
//            The selected channel cycles rising (start), falling (high time),
//            rising (period); the third beat launches a measurement.
//   out_ch : one result beat per completed period: frequency = clock_hz /
//            period, duty = high * 100 / period clamped at 100, status 1 and
//            zeros when the period is zero.
//   cfg_*  : write enable, index (0 active_channel, 1 clock_hz), data.
// Flow: a beat that does not close a period keeps in_ch.ready high. A
//   closing beat holds in_ch.ready low while the period is latched, the
//   bit-serial divider runs (one quotient bit per cycle on both lanes) and
//   the result is handed to the output register; a zero period skips the
//   divider iterations.
// Stall: the output register holds a result while out_ch.ready is low; a
//   second result waits in the divider and in_ch.ready stays low.
// Reset: both channels return to start phase, control registers to defaults.
// ----------------------------------------------------------------------------
module pwm_frequency_duty_meter (
  input  logic                                clk,
  input  logic                                rst_n,
  pfdm_in_if.sink                             in_ch,
  pfdm_out_if.source                          out_ch,
  input  logic                                cfg_wr_en,
  input  logic [pfdm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [pfdm_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

  logic                            active_channel_r;
  logic [pfdm_pkg::CLOCK_BITS-1:0] clock_hz_r;
  logic                            in_fire;
  logic                            job_valid;
  pfdm_pkg::job_t                  job;
  logic                            div_idle;
  logic                            res_valid;
  logic                            res_ready;
  pfdm_pkg::result_t               div_res;
  logic                            out_valid_r;
  pfdm_pkg::result_t               out_res_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_channel_r <= 1'b0;
      clock_hz_r       <= pfdm_pkg::CLOCK_HZ_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        pfdm_pkg::CFG_ACTIVE_CHANNEL: active_channel_r <= cfg_wdata[0];
        pfdm_pkg::CFG_CLOCK_HZ:       clock_hz_r       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Accept edges only while no measurement is in flight
  assign in_ch.ready = div_idle && !job_valid;
  assign in_fire     = in_ch.valid && in_ch.ready;

  pfdm_tracker u_tracker (
    .clk            (clk),
    .rst_n          (rst_n),
    .fire           (in_fire),
    .channel        (in_ch.channel),
    .stamp          (in_ch.stamp),
    .active_channel (active_channel_r),
    .job_valid      (job_valid),
    .job            (job)
  );

  pfdm_divider u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (job_valid),
    .job       (job),
    .clock_hz  (clock_hz_r),
    .idle      (div_idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .result    (div_res)
  );

  // Output register: load when empty or draining
  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= div_res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_channel  = out_res_r.ch;
  assign out_ch.frequency    = out_res_r.frequency;
  assign out_ch.duty_percent = out_res_r.duty_percent;
  assign out_ch.status       = out_res_r.status;

endmodule

@@ hdl/pfdm_checker.sv @@
// ----------------------------------------------------------------------------
// PWM meter port checker
// Concurrent checks on the top-level ports, bound into the meter.
// ----------------------------------------------------------------------------
`include "pwm_frequency_duty_meter_assert.svh"

module pfdm_port_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            out_channel,
  input logic [pfdm_pkg::CLOCK_BITS-1:0] frequency,
  input logic [pfdm_pkg::DUTY_BITS-1:0]  duty_percent,
  input logic                            status
);

  // Stalled result beat holds
  `PFDM_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_channel) && $stable(frequency)
      && $stable(duty_percent) && $stable(status))

  // Duty never exceeds full scale
  `PFDM_ASSERT_IMP(a_duty_range, out_valid, duty_percent <= pfdm_pkg::DUTY_FULL)

  // Zero period reports zeros
  `PFDM_ASSERT_IMP(a_zero_period, out_valid && status == pfdm_pkg::STATUS_ZERO_PERIOD,
    frequency == '0 && duty_percent == '0)

  // A new result only follows a cycle in which capture input was blocked
  `PFDM_ASSERT_IMP(a_busy_before_out, $rose(out_valid), $past(!in_ready))

endmodule

bind pwm_frequency_duty_meter pfdm_port_checker u_pfdm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_channel  (out_ch.out_channel),
  .frequency    (out_ch.frequency),
  .duty_percent (out_ch.duty_percent),
  .status       (out_ch.status)
);
